FILE: rtl/rpc_pkg.sv
package rpc_pkg;

	localparam int KEY_LETTERS_MAX = 30;
	localparam int ROW_LETTERS     = 10;
	localparam int SET_SIZE        = 20;
	localparam int ALPHA_N         = 5;
	localparam int LETTER_W        = 5;
	localparam int ROW_W           = ROW_LETTERS * LETTER_W;

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;
	localparam logic [7:0] CASE_GAP = 8'd32;
	localparam logic [7:0] CH_U     = 8'h55;
	localparam logic [7:0] CH_V     = 8'h56;

	typedef logic [LETTER_W-1:0] letter_t;

	typedef enum logic [2:0] {
		REG_UPPER_ROW      = 3'd0,
		REG_LOWER_ROW      = 3'd1,
		REG_KEY_FIRST_TEN  = 3'd2,
		REG_KEY_SECOND_TEN = 3'd3,
		REG_KEY_THIRD_TEN  = 3'd4,
		REG_KEY_LENGTH     = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [ROW_W-1:0]    upper_row;
		logic [ROW_W-1:0]    lower_row;
		logic [ROW_W-1:0]    key_first_ten;
		logic [ROW_W-1:0]    key_second_ten;
		logic [ROW_W-1:0]    key_third_ten;
		logic [LETTER_W-1:0] key_length;
	} rpc_cfg_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       not_in_alphabet;
		logic       bad_key;
		logic [2:0] alphabet_used;
	} rpc_result_t;

	typedef struct packed {
		logic    found;
		letter_t idx;
	} letter_hit_t;

	// ASCII of a letter index; indexes outside the set give NUL
	function automatic logic [7:0] letter_char(input letter_t idx);
		logic [7:0] c;
		case (idx)
			5'd0:    c = "A";
			5'd1:    c = "B";
			5'd2:    c = "C";
			5'd3:    c = "D";
			5'd4:    c = "E";
			5'd5:    c = "F";
			5'd6:    c = "G";
			5'd7:    c = "H";
			5'd8:    c = "I";
			5'd9:    c = "L";
			5'd10:   c = "M";
			5'd11:   c = "N";
			5'd12:   c = "O";
			5'd13:   c = "P";
			5'd14:   c = "Q";
			5'd15:   c = "R";
			5'd16:   c = "S";
			5'd17:   c = "T";
			5'd18:   c = "V";
			5'd19:   c = "Z";
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic letter_hit_t letter_of(input logic [7:0] c);
		letter_hit_t h;
		h.found = 1'b1;
		case (c)
			"A":     h.idx = 5'd0;
			"B":     h.idx = 5'd1;
			"C":     h.idx = 5'd2;
			"D":     h.idx = 5'd3;
			"E":     h.idx = 5'd4;
			"F":     h.idx = 5'd5;
			"G":     h.idx = 5'd6;
			"H":     h.idx = 5'd7;
			"I":     h.idx = 5'd8;
			"L":     h.idx = 5'd9;
			"M":     h.idx = 5'd10;
			"N":     h.idx = 5'd11;
			"O":     h.idx = 5'd12;
			"P":     h.idx = 5'd13;
			"Q":     h.idx = 5'd14;
			"R":     h.idx = 5'd15;
			"S":     h.idx = 5'd16;
			"T":     h.idx = 5'd17;
			"V":     h.idx = 5'd18;
			"Z":     h.idx = 5'd19;
			default: begin
				h.found = 1'b0;
				h.idx   = 5'd0;
			end
		endcase
		return h;
	endfunction

endpackage

FILE: rtl/rpc_subst.sv
module rpc_subst (
	input  rpc_pkg::rpc_cfg_t    cfg,
	input  logic [7:0]           char_in,
	input  logic [4:0]           key_pos,
	output rpc_pkg::rpc_result_t res,
	output logic [4:0]           key_pos_next
);
	import rpc_pkg::*;

	letter_t     upper [ROW_LETTERS];
	letter_t     lower [ROW_LETTERS];
	letter_t     rot   [ROW_LETTERS];
	letter_t     keyw  [ROW_LETTERS];
	logic [4:0]  len;
	logic [4:0]  pos;
	logic [3:0]  kidx;
	logic [ROW_W-1:0] kword;
	letter_t     key;
	logic [2:0]  alpha;
	logic        bad;
	logic        white;
	logic [7:0]  folded;
	letter_hit_t hit;
	logic [7:0]  subst;
	logic [5:0]  pos_inc;

	always_comb begin
		for (int i = 0; i < ROW_LETTERS; i++) begin
			upper[i] = cfg.upper_row[i*LETTER_W +: LETTER_W];
			lower[i] = cfg.lower_row[i*LETTER_W +: LETTER_W];
		end
	end

	// effective key length and clamped position
	always_comb begin
		if (cfg.key_length == '0)
			len = 5'd1;
		else if (cfg.key_length > KEY_LETTERS_MAX[4:0])
			len = KEY_LETTERS_MAX[4:0];
		else
			len = cfg.key_length;
		pos = (key_pos >= len) ? 5'd0 : key_pos;
		if (pos < 5'(ROW_LETTERS)) begin
			kword = cfg.key_first_ten;
			kidx  = pos[3:0];
		end else if (pos < 5'(2*ROW_LETTERS)) begin
			kword = cfg.key_second_ten;
			kidx  = 4'(pos - 5'(ROW_LETTERS));
		end else begin
			kword = cfg.key_third_ten;
			kidx  = 4'(pos - 5'(2*ROW_LETTERS));
		end
		for (int i = 0; i < ROW_LETTERS; i++)
			keyw[i] = kword[i*LETTER_W +: LETTER_W];
		key = keyw[kidx];
	end

	// first alphabet whose id holds the key letter
	always_comb begin
		alpha = 3'd0;
		bad   = 1'b1;
		if (key < letter_t'(SET_SIZE)) begin
			for (int i = ALPHA_N - 1; i >= 0; i--) begin
				if (upper[i] == key || lower[i] == key ||
				    upper[i+ALPHA_N] == key || lower[i+ALPHA_N] == key) begin
					alpha = 3'(i);
					bad   = 1'b0;
				end
			end
		end
	end

	// lower row rotated right by alpha
	always_comb begin
		int j;
		for (int i = 0; i < ROW_LETTERS; i++) begin
			j = i + ROW_LETTERS - int'(alpha);
			if (j >= ROW_LETTERS)
				j = j - ROW_LETTERS;
			rot[i] = lower[j[3:0]];
		end
	end

	always_comb begin
		white  = (char_in == CH_SPACE) || (char_in == CH_LF) || (char_in == CH_CR) ||
		         (char_in == CH_TAB) || (char_in == CH_NUL);
		folded = char_in;
		if (folded >= CH_LOW_A && folded <= CH_LOW_Z)
			folded = folded - CASE_GAP;
		if (folded == CH_U)
			folded = CH_V;
		hit = letter_of(folded);
		// lowest column wins, row 0 before row 1 within a column
		subst = CH_NUL;
		for (int i = ROW_LETTERS - 1; i >= 0; i--) begin
			if (upper[i] == hit.idx)
				subst = letter_char(rot[i]);
			else if (rot[i] == hit.idx)
				subst = letter_char(upper[i]);
		end
	end

	always_comb begin
		pos_inc = {1'b0, key_pos} + 6'd1;
		key_pos_next = key_pos;
		if (white)
			key_pos_next = (pos_inc >= {1'b0, len}) ? 5'd0 : pos_inc[4:0];

		res.bad_key       = bad;
		res.alphabet_used = alpha;
		if (white) begin
			res.char_out        = CH_SPACE;
			res.not_in_alphabet = 1'b0;
		end else if (!hit.found) begin
			res.char_out        = CH_NUL;
			res.not_in_alphabet = 1'b1;
		end else begin
			res.char_out        = subst;
			res.not_in_alphabet = 1'b0;
		end
	end

endmodule

FILE: rtl/reciprocal_polyalphabetic_cipher.sv
// Reciprocal polyalphabetic substitution over the 20-letter set ABCDEFGHILMNOPQRSTVZ:
// one ASCII character in, one character out, and the same step enciphers and
// deciphers. The input word is registered, substituted by a single pass of
// parallel compares over the ten table columns, and registered again at the
// output, so a word is accepted every cycle unless the output stalls; the only
// feedback is the key position register, which moves on whitespace when the
// word leaves the first stage. Load both alphabet rows, the key letters and
// the key length through the config port while the stream is idle; building
// rows from a keyword is left to software.
module reciprocal_polyalphabetic_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_index,
	input  logic [49:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_in[7:0]
	input  logic [0:0]  s_tuser,   // message_start[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // char_out[7:0], alphabet_used[10:8], zero[15:11]
	output logic [1:0]  m_tuser    // not_in_alphabet[0], bad_key[1]
);
	import rpc_pkg::*;

	rpc_cfg_t    cfg_q;
	logic [4:0]  key_pos_q;
	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        start_s1;
	logic        valid_s2;
	rpc_result_t res_s2;
	rpc_result_t res;
	logic [4:0]  key_pos;
	logic [4:0]  key_pos_next;
	logic        adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upper_row      <= '0;
			cfg_q.lower_row      <= '0;
			cfg_q.key_first_ten  <= '0;
			cfg_q.key_second_ten <= '0;
			cfg_q.key_third_ten  <= '0;
			cfg_q.key_length     <= 5'd1;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_UPPER_ROW:      cfg_q.upper_row      <= cfg_data;
				REG_LOWER_ROW:      cfg_q.lower_row      <= cfg_data;
				REG_KEY_FIRST_TEN:  cfg_q.key_first_ten  <= cfg_data;
				REG_KEY_SECOND_TEN: cfg_q.key_second_ten <= cfg_data;
				REG_KEY_THIRD_TEN:  cfg_q.key_third_ten  <= cfg_data;
				REG_KEY_LENGTH:     cfg_q.key_length     <= cfg_data[LETTER_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign key_pos  = start_s1 ? 5'd0 : key_pos_q;

	rpc_subst u_subst (
		.cfg          (cfg_q),
		.char_in      (char_s1),
		.key_pos      (key_pos),
		.res          (res),
		.key_pos_next (key_pos_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			key_pos_q <= 5'd0;
		end else begin
			if (s_tvalid && s_tready)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv) begin
				valid_s2 <= valid_s1;
				if (valid_s1)
					key_pos_q <= key_pos_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1  <= s_tdata;
			start_s1 <= s_tuser[0];
		end
		if (adv && valid_s1)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, res_s2.alphabet_used, res_s2.char_out};
	assign m_tuser  = {res_s2.bad_key, res_s2.not_in_alphabet};

	// key position never leaves the key letter range
	a_key_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		key_pos_q < KEY_LETTERS_MAX[4:0])
		else $error("key position out of range");

	// first stage holds its word while the output is blocked
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(char_s1))
		else $error("first stage lost a word under stall");

	// key position moves only when a word leaves the first stage
	a_key_pos_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && adv) |=> $stable(key_pos_q))
		else $error("key position changed without a word");

	a_unknown_nul: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[7:0] == CH_NUL)
		else $error("unknown character without NUL");

	a_bad_key_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[10:8] == 3'd0)
		else $error("bad key with nonzero alphabet");

endmodule

FILE: sim/reciprocal_polyalphabetic_cipher_tb.sv
module reciprocal_polyalphabetic_cipher_tb;
	import rpc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT    = 31;
	localparam int CALM_FROM   = 300;
	localparam int CALM_TO     = 650;
	localparam int HOLD_AT     = 900;
	localparam int HOLD_CYCLES = 250;
	localparam int RAND_PHASES = 15;
	localparam int PHASE_WORDS = 100;

	// indexes past the register list, written once to see that they are dropped
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	localparam logic [8*SET_SIZE-1:0] CIPHER_SET = "ABCDEFGHILMNOPQRSTVZ";
	localparam logic [ROW_W-1:0]      ROW_ONES   = '1;

	typedef struct packed {
		logic [7:0] ch;
		logic       start;
	} char_word_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [49:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // char_in[7:0]
	logic [0:0]  s_tuser   = '0;   // message_start[0]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;          // char_out[7:0], alphabet_used[10:8], zero[15:11]
	logic [1:0]  m_tuser;          // not_in_alphabet[0], bad_key[1]

	// shadow of the block's registers and key pointer
	logic [ROW_W-1:0]    shd_upper = '0;
	logic [ROW_W-1:0]    shd_lower = '0;
	logic [ROW_W-1:0]    shd_key [3] = '{'0, '0, '0};
	logic [LETTER_W-1:0] shd_len = 5'd1;
	int                  key_pos = 0;

	char_word_t  pending_words[$];
	rpc_result_t expected_out[$];
	char_word_t  cur_word, nxt_word;
	rpc_result_t got_out, want_out;

	bit word_taken = 1'b0;
	bit hold_done  = 1'b0;
	int hold_left  = 0;
	int words_in   = 0;
	int words_out  = 0;
	int mismatches = 0;
	int cycles     = 0;
	int settings   = 0;

	wire quiet = (words_in >= CALM_FROM) && (words_in < CALM_TO);

	reciprocal_polyalphabetic_cipher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #6 clk = ~clk;

	function automatic int letter_at(input logic [ROW_W-1:0] row, input int col);
		return int'(row[col*LETTER_W +: LETTER_W]);
	endfunction

	function automatic logic [7:0] set_char(input int idx);
		return CIPHER_SET[8*(SET_SIZE-1-idx) +: 8];
	endfunction

	// one step of the cipher; clears key_pos on a message start, moves it on whitespace
	function automatic rpc_result_t cipher_predict(input char_word_t w);
		rpc_result_t r;
		int         len, pos, key, alpha, letter, up, lo;
		bit         bad, found, hit;
		logic [7:0] c;
		r      = '0;
		alpha  = 0;
		letter = 0;
		bad    = 1'b1;
		found  = 1'b0;
		hit    = 1'b0;
		if (w.start)
			key_pos = 0;
		len = int'(shd_len);
		if (len == 0)
			len = 1;
		if (len > KEY_LETTERS_MAX)
			len = KEY_LETTERS_MAX;
		pos = key_pos;
		if (pos >= len)
			pos = 0;
		key = letter_at(shd_key[pos / ROW_LETTERS], pos % ROW_LETTERS);
		if (key < SET_SIZE) begin
			for (int i = 0; i < ALPHA_N; i++) begin
				if (bad && (letter_at(shd_upper, i) == key || letter_at(shd_lower, i) == key ||
				            letter_at(shd_upper, i + ALPHA_N) == key ||
				            letter_at(shd_lower, i + ALPHA_N) == key)) begin
					alpha = i;
					bad   = 1'b0;
				end
			end
		end
		c = w.ch;
		if (c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB || c == CH_NUL) begin
			r.char_out = CH_SPACE;
			key_pos    = (key_pos + 1 >= len) ? 0 : key_pos + 1;
		end else begin
			if (c >= CH_LOW_A && c <= CH_LOW_Z)
				c = c - CASE_GAP;
			if (c == CH_U)
				c = CH_V;
			for (int i = 0; i < SET_SIZE; i++) begin
				if (!found && set_char(i) == c) begin
					letter = i;
					found  = 1'b1;
				end
			end
			if (!found) begin
				r.not_in_alphabet = 1'b1;
			end else begin
				// lower row is rotated right by the alphabet index
				for (int i = 0; i < ROW_LETTERS; i++) begin
					if (!hit) begin
						up = letter_at(shd_upper, i);
						lo = letter_at(shd_lower, (i + ROW_LETTERS - alpha) % ROW_LETTERS);
						if (up == letter) begin
							if (lo < SET_SIZE)
								r.char_out = set_char(lo);
							hit = 1'b1;
						end else if (lo == letter) begin
							if (up < SET_SIZE)
								r.char_out = set_char(up);
							hit = 1'b1;
						end
					end
				end
			end
		end
		r.bad_key       = bad;
		r.alphabet_used = 3'(alpha);
		return r;
	endfunction

	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
		end
	endtask

	// input side: take the word at the edge, predict its result
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			cur_word.ch    = s_tdata;
			cur_word.start = s_tuser[0];
			expected_out.push_back(cipher_predict(cur_word));
			words_in++;
			word_taken = 1'b1;
		end
	end

	// output side
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			words_out++;
			got_out.char_out        = m_tdata[7:0];
			got_out.alphabet_used   = m_tdata[10:8];
			got_out.not_in_alphabet = m_tuser[0];
			got_out.bad_key         = m_tuser[1];
			if (expected_out.size() == 0) begin
				mismatches++;
				$display("%0t: result word with nothing expected, expected none, actual %h",
				         $time, got_out);
			end else begin
				want_out = expected_out.pop_front();
				check_field("char_out", want_out.char_out, got_out.char_out);
				check_field("not_in_alphabet", want_out.not_in_alphabet, got_out.not_in_alphabet);
				check_field("bad_key", want_out.bad_key, got_out.bad_key);
				check_field("alphabet_used", want_out.alphabet_used, got_out.alphabet_used);
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || word_taken) begin
			word_taken = 1'b0;
			if (pending_words.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
				nxt_word = pending_words.pop_front();
				s_tdata  <= nxt_word.ch;
				s_tuser  <= nxt_word.start;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver; one long hold-off so the pipe backs up into the input
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!hold_done && words_in >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cycles,
			         expected_out.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [ROW_W-1:0] val);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_UPPER_ROW:      shd_upper  = val;
			REG_LOWER_ROW:      shd_lower  = val;
			REG_KEY_FIRST_TEN:  shd_key[0] = val;
			REG_KEY_SECOND_TEN: shd_key[1] = val;
			REG_KEY_THIRD_TEN:  shd_key[2] = val;
			REG_KEY_LENGTH:     shd_len    = val[LETTER_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic push_word(input logic [7:0] ch, input logic start);
		char_word_t w;
		w.ch    = ch;
		w.start = start;
		pending_words.push_back(w);
	endtask

	task automatic wait_drain();
		while (pending_words.size() != 0 || s_tvalid || expected_out.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// upper row A..L, lower row M..Z
	task automatic load_plain_rows();
		logic [ROW_W-1:0] up, lo;
		for (int i = 0; i < ROW_LETTERS; i++) begin
			up[i*LETTER_W +: LETTER_W] = LETTER_W'(i);
			lo[i*LETTER_W +: LETTER_W] = LETTER_W'(i + ROW_LETTERS);
		end
		write_reg(REG_UPPER_ROW, up);
		write_reg(REG_LOWER_ROW, lo);
	endtask

	function automatic logic [ROW_W-1:0] random_key_word();
		logic [ROW_W-1:0] k;
		if ($urandom_range(7) == 0)
			return ROW_W'({$urandom, $urandom});
		for (int i = 0; i < ROW_LETTERS; i++)
			k[i*LETTER_W +: LETTER_W] = ($urandom_range(19) == 0) ?
				LETTER_W'($urandom_range(31)) : LETTER_W'($urandom_range(SET_SIZE - 1));
		return k;
	endfunction

	task automatic random_setup();
		int               perm [SET_SIZE];
		int               j, t, sel;
		logic [ROW_W-1:0] up, lo;
		logic [4:0]       len;
		for (int i = 0; i < SET_SIZE; i++)
			perm[i] = i;
		for (int i = SET_SIZE - 1; i > 0; i--) begin
			j       = $urandom_range(i);
			t       = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		for (int i = 0; i < ROW_LETTERS; i++) begin
			up[i*LETTER_W +: LETTER_W] = LETTER_W'(perm[i]);
			lo[i*LETTER_W +: LETTER_W] = LETTER_W'(perm[i + ROW_LETTERS]);
		end
		// mostly clean tables, sometimes damaged ones
		sel = $urandom_range(9);
		if (sel == 0)
			up = ROW_W'({$urandom, $urandom});
		else if (sel == 1)
			lo = ROW_W'({$urandom, $urandom});
		else if (sel == 2)
			up[$urandom_range(ROW_LETTERS - 1)*LETTER_W +: LETTER_W] =
				LETTER_W'($urandom_range(31, SET_SIZE));
		else if (sel == 3)
			lo[$urandom_range(ROW_LETTERS - 1)*LETTER_W +: LETTER_W] =
				up[$urandom_range(ROW_LETTERS - 1)*LETTER_W +: LETTER_W];
		write_reg(REG_UPPER_ROW, up);
		write_reg(REG_LOWER_ROW, lo);
		write_reg(REG_KEY_FIRST_TEN, random_key_word());
		write_reg(REG_KEY_SECOND_TEN, random_key_word());
		write_reg(REG_KEY_THIRD_TEN, random_key_word());
		case ($urandom_range(9))
			0:       len = 5'd0;
			1:       len = 5'(KEY_LETTERS_MAX);
			2:       len = 5'd31;
			3:       len = 5'($urandom_range(31));
			default: len = 5'($urandom_range(12, 1));
		endcase
		write_reg(REG_KEY_LENGTH, ROW_W'(len));
		settings++;
	endtask

	function automatic logic [7:0] random_letter();
		logic [7:0] c;
		c = ($urandom_range(9) == 0) ? CH_U : set_char($urandom_range(SET_SIZE - 1));
		if ($urandom_range(1) == 1)
			c = c + CASE_GAP;
		return c;
	endfunction

	function automatic logic [7:0] random_blank();
		case ($urandom_range(4))
			0:       return CH_TAB;
			1:       return CH_LF;
			2:       return CH_CR;
			3:       return CH_NUL;
			default: return CH_SPACE;
		endcase
	endfunction

	// messages of words and blanks, with some noise and stray restarts
	task automatic random_text(input int count);
		int left, msg_len;
		left = count;
		while (left > 0) begin
			msg_len = $urandom_range(40, 5);
			if (msg_len > left)
				msg_len = left;
			for (int i = 0; i < msg_len; i++) begin
				if ($urandom_range(9) == 0)
					push_word(8'($urandom_range(255)), ($urandom_range(3) == 0));
				else if ($urandom_range(4) == 0)
					push_word(random_blank(), (i == 0) || ($urandom_range(29) == 0));
				else
					push_word(random_letter(), (i == 0) || ($urandom_range(29) == 0));
			end
			left -= msg_len;
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset tables: everything is letter A, most letters are missing
		push_word("A", 1'b0);
		push_word("B", 1'b0);
		push_word("?", 1'b0);
		wait_drain();

		// plain table, key A N <invalid>, length 3
		load_plain_rows();
		write_reg(REG_KEY_FIRST_TEN, ROW_W'({5'd31, 5'd11, 5'd0}));
		write_reg(REG_KEY_SECOND_TEN, {ROW_LETTERS{5'd19}});
		write_reg(REG_KEY_THIRD_TEN, '0);
		write_reg(REG_KEY_LENGTH, ROW_W'(3));
		settings++;
		push_word("A", 1'b1);
		push_word("z", 1'b0);
		push_word(CH_SPACE, 1'b0);
		push_word("u", 1'b0);
		push_word("U", 1'b0);
		push_word(CH_CR, 1'b0);
		push_word("V", 1'b0);
		push_word("q", 1'b0);
		push_word(CH_LF, 1'b0);
		push_word("?", 1'b0);
		push_word(CH_TAB, 1'b0);
		push_word(8'hFF, 1'b0);
		push_word(CH_NUL, 1'b0);
		push_word(8'h80, 1'b0);
		push_word("M", 1'b1);
		push_word("7", 1'b0);
		push_word("e", 1'b0);
		wait_drain();

		// all ones everywhere; length 31 acts as the maximum
		write_reg(REG_UPPER_ROW, ROW_ONES);
		write_reg(REG_LOWER_ROW, ROW_ONES);
		write_reg(REG_KEY_FIRST_TEN, ROW_ONES);
		write_reg(REG_KEY_SECOND_TEN, ROW_ONES);
		write_reg(REG_KEY_THIRD_TEN, ROW_ONES);
		write_reg(REG_KEY_LENGTH, ROW_ONES);
		write_reg(REG_SPARE_LO, '0);
		write_reg(REG_SPARE_HI, '0);
		settings++;
		push_word("A", 1'b0);
		push_word(CH_SPACE, 1'b0);
		push_word(CH_SPACE, 1'b0);
		push_word("b", 1'b0);
		wait_drain();

		// length 0 with the pointer left past it
		load_plain_rows();
		write_reg(REG_KEY_FIRST_TEN, ROW_W'({5'd8, 5'd4, 5'd17}));
		write_reg(REG_KEY_LENGTH, '0);
		settings++;
		push_word("C", 1'b0);
		push_word(CH_SPACE, 1'b0);
		push_word("C", 1'b0);
		wait_drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			random_setup();
			random_text(PHASE_WORDS);
			wait_drain();
		end

		repeat (8) @(posedge clk);
		$display("sent %0d characters, checked %0d results across %0d table and key settings",
		         words_in, words_out, settings);
		$display("%0d mismatches, %0d results never arrived", mismatches, expected_out.size());
		if (mismatches == 0 && expected_out.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
